### design/srp_pkg.sv
// Shared types and constants for the schedule record parser.
`default_nettype none

package srp_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW = 2;
  localparam int unsigned FifoCntW = 3;

  localparam logic [9:0] MaxEntriesReset = 10'd64;

  localparam logic [7:0] ChSemicolon = 8'h3b;
  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChNl = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  localparam logic [1:0] DigitsPerValue = 2'd3;  // last index of a four-digit value

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_DIGIT    = 3'd0,
    ERR_SPACE    = 3'd1,
    ERR_FOUR_DIG = 3'd2,
    ERR_NEWLINE  = 3'd3,
    ERR_TOO_MANY = 3'd4
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  day;
    logic [13:0] start_val;
    logic [13:0] end_val;
    logic [9:0]  entry_count;
    err_e        error_code;
    logic [15:0] line_number;
    logic        last;
  } srp_result_t;

  typedef struct packed {
    logic [1:0]  num;
    srp_result_t first;
    srp_result_t second;
  } srp_push_t;

endpackage

`default_nettype wire

### design/srp_parser.sv
// Parser state machine: one byte per step, up to two results per step.
`default_nettype none

module srp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        char_byte_i,
  input  wire logic              end_of_file_i,
  input  wire logic [9:0]        max_entries_i,
  output srp_pkg::srp_push_t     push_o
);

  typedef enum logic [3:0] {
    PH_LINE    = 4'd0,
    PH_COMMENT = 4'd1,
    PH_SP1     = 4'd2,
    PH_DIG1    = 4'd3,
    PH_SP2     = 4'd4,
    PH_DIG2    = 4'd5,
    PH_NL      = 4'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  digit_index_q, digit_index_d;
  logic [13:0] acc_q, acc_d;
  logic [3:0]  held_day_q, held_day_d;
  logic [13:0] held_start_q, held_start_d;
  logic [9:0]  count_q, count_d;
  logic [15:0] line_q, line_d;
  logic        cr_q, cr_d;
  logic        draining_q, draining_d;

  logic        eof, is_dig, is_sp, is_nl;
  logic        line_start, entry, fin, do_new;
  srp_pkg::kind_e kind_fin;
  srp_pkg::err_e  code_fin;
  logic [15:0] line_bump;
  logic [13:0] acc_next;
  srp_pkg::srp_result_t rec_entry, rec_fin;

  assign eof       = end_of_file_i;
  assign is_dig    = !eof && char_byte_i >= srp_pkg::ChZero && char_byte_i <= srp_pkg::ChNine;
  assign is_sp     = !eof && char_byte_i == srp_pkg::ChSpace;
  assign is_nl     = !eof && char_byte_i == srp_pkg::ChNl;
  assign line_bump = (line_q == 16'hffff) ? line_q : line_q + 16'd1;
  assign acc_next  = (acc_q << 3) + (acc_q << 1) + {10'd0, char_byte_i[3:0]};

  always_comb begin
    phase_d       = phase_q;
    digit_index_d = digit_index_q;
    acc_d         = acc_q;
    held_day_d    = held_day_q;
    held_start_d  = held_start_q;
    count_d       = count_q;
    line_d        = line_q;
    cr_d          = cr_q;
    draining_d    = draining_q;
    line_start    = 1'b0;
    entry         = 1'b0;
    fin           = 1'b0;
    do_new        = 1'b0;
    kind_fin      = srp_pkg::KIND_DONE;
    code_fin      = srp_pkg::ERR_DIGIT;

    if (step_i) begin
      if (draining_q) begin
        // discard bytes through the next end marker
        if (eof) begin
          draining_d = 1'b0;
          do_new     = 1'b1;
        end
      end else if (!eof && char_byte_i == srp_pkg::ChCr && !cr_q) begin
        cr_d = 1'b1;
      end else begin
        cr_d = 1'b0;
        unique case (phase_q)
          PH_COMMENT: begin
            if (eof) begin
              line_start = 1'b1;
            end else if (is_nl) begin
              line_d  = line_bump;
              phase_d = PH_LINE;
            end
          end
          PH_SP1, PH_SP2: begin
            if (!is_sp) begin
              fin      = 1'b1;
              kind_fin = srp_pkg::KIND_ERROR;
              code_fin = srp_pkg::ERR_SPACE;
            end else begin
              phase_d       = (phase_q == PH_SP1) ? PH_DIG1 : PH_DIG2;
              digit_index_d = 2'd0;
              acc_d         = 14'd0;
            end
          end
          PH_DIG1, PH_DIG2: begin
            if (!is_dig) begin
              fin      = 1'b1;
              kind_fin = srp_pkg::KIND_ERROR;
              code_fin = srp_pkg::ERR_FOUR_DIG;
            end else begin
              acc_d         = acc_next;
              digit_index_d = digit_index_q + 2'd1;
              if (digit_index_q == srp_pkg::DigitsPerValue) begin
                if (phase_q == PH_DIG1) begin
                  held_start_d = acc_next;
                  phase_d      = PH_SP2;
                end else begin
                  phase_d = PH_NL;
                end
              end
            end
          end
          PH_NL: begin
            if (!is_nl) begin
              fin      = 1'b1;
              kind_fin = srp_pkg::KIND_ERROR;
              code_fin = srp_pkg::ERR_NEWLINE;
            end else begin
              entry   = 1'b1;
              count_d = count_q + 10'd1;
              line_d  = line_bump;
              phase_d = PH_LINE;
              if (count_d >= max_entries_i) begin
                fin      = 1'b1;
                kind_fin = srp_pkg::KIND_ERROR;
                code_fin = srp_pkg::ERR_TOO_MANY;
              end
            end
          end
          default: line_start = 1'b1;
        endcase

        if (line_start) begin
          phase_d = PH_LINE;
          priority if (count_q >= max_entries_i) begin
            fin      = 1'b1;
            kind_fin = srp_pkg::KIND_ERROR;
            code_fin = srp_pkg::ERR_TOO_MANY;
          end else if (eof) begin
            fin      = 1'b1;
            kind_fin = srp_pkg::KIND_DONE;
          end else if (char_byte_i == srp_pkg::ChSemicolon) begin
            phase_d = PH_COMMENT;
          end else if (is_nl) begin
            line_d = line_bump;
          end else if (is_dig) begin
            held_day_d = char_byte_i[3:0];
            phase_d    = PH_SP1;
          end else begin
            fin      = 1'b1;
            kind_fin = srp_pkg::KIND_ERROR;
            code_fin = srp_pkg::ERR_DIGIT;
          end
        end
      end
    end

    rec_entry.kind        = srp_pkg::KIND_ENTRY;
    rec_entry.day         = held_day_q;
    rec_entry.start_val   = held_start_q;
    rec_entry.end_val     = acc_q;
    rec_entry.entry_count = count_d;
    rec_entry.error_code  = srp_pkg::ERR_DIGIT;
    rec_entry.line_number = line_q;
    rec_entry.last        = !fin;

    rec_fin.kind        = kind_fin;
    rec_fin.day         = 4'd0;
    rec_fin.start_val   = 14'd0;
    rec_fin.end_val     = 14'd0;
    rec_fin.entry_count = count_d;
    rec_fin.error_code  = (kind_fin == srp_pkg::KIND_ERROR) ? code_fin : srp_pkg::ERR_DIGIT;
    rec_fin.line_number = line_d;
    rec_fin.last        = 1'b1;

    // a final result on the end marker restarts, on a byte it drains
    if (fin) begin
      if (eof) begin
        do_new = 1'b1;
      end else begin
        draining_d = 1'b1;
      end
    end

    if (do_new) begin
      phase_d       = PH_LINE;
      digit_index_d = 2'd0;
      acc_d         = 14'd0;
      held_day_d    = 4'd0;
      held_start_d  = 14'd0;
      count_d       = 10'd0;
      line_d        = 16'd1;
      cr_d          = 1'b0;
    end

    push_o.num    = {1'b0, entry} + {1'b0, fin};
    push_o.first  = entry ? rec_entry : rec_fin;
    push_o.second = rec_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_LINE;
      digit_index_q <= 2'd0;
      acc_q         <= 14'd0;
      held_day_q    <= 4'd0;
      held_start_q  <= 14'd0;
      count_q       <= 10'd0;
      line_q        <= 16'd1;
      cr_q          <= 1'b0;
      draining_q    <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      digit_index_q <= digit_index_d;
      acc_q         <= acc_d;
      held_day_q    <= held_day_d;
      held_start_q  <= held_start_d;
      count_q       <= count_d;
      line_q        <= line_d;
      cr_q          <= cr_d;
      draining_q    <= draining_d;
    end
  end

endmodule

`default_nettype wire

### design/srp_out_fifo.sv
// Four-entry result queue, takes up to two results per cycle.
`default_nettype none

module srp_out_fifo (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire srp_pkg::srp_push_t                  push_i,
  input  wire logic                                pop_i,
  output srp_pkg::srp_result_t                     head_o,
  output logic [srp_pkg::FifoCntW-1:0]             count_o
);

  srp_pkg::srp_result_t mem_q [srp_pkg::FifoDepth];
  logic [srp_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [srp_pkg::FifoCntW-1:0] count_q, count_d;
  logic [srp_pkg::FifoPtrW-1:0] wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + srp_pkg::FifoPtrW'(1);
  assign head_o    = mem_q[rd_ptr_q];
  assign count_o   = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.num;
    rd_ptr_d = pop_i ? rd_ptr_q + srp_pkg::FifoPtrW'(1) : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i.num} - {{(srp_pkg::FifoCntW-1){1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### design/schedule_record_parser.sv
// Top level: parses "D HHHH HHHH" schedule lines from a byte stream.
//
// Input channel: in_valid_i / in_stall_o carry one byte (char_byte_i) or an
// end marker (end_of_file_i). A transaction lands in an input register; the
// parser steps on it once the queue has room, writing up to two results to a
// four-entry output queue. One byte per cycle is sustained while the queue has
// room; a byte that completes a record at the entry limit makes two results.
// Output channel: out_valid_o / out_stall_i carry one result per
// transaction: an entry, a success or an error, with last_o set on the final
// result of a byte. While out_stall_i is high the queue fills; once it cannot
// take two more results the input register holds and in_stall_o rises.
// Configuration: cfg_valid_i / cfg_ready_o write max_entries; ready is
// always high and writes are meant for when the block is idle.
// Reset clears the parser to line start, count 0, line 1, empties the
// queue and sets max_entries to 64.
`default_nettype none

module schedule_record_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [9:0]  cfg_max_entries_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [3:0]       day_o,
  output logic [13:0]      start_val_o,
  output logic [13:0]      end_val_o,
  output logic [9:0]       entry_count_o,
  output logic [2:0]       error_code_o,
  output logic [15:0]      line_number_o,
  output logic             last_o
);

  logic [9:0] max_entries_q;
  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q;
  logic       eof_q;
  logic       accept, advance, pop;
  logic [srp_pkg::FifoCntW-1:0] fifo_cnt;
  srp_pkg::srp_push_t   push;
  srp_pkg::srp_result_t head;

  assign cfg_ready_o = 1'b1;

  // step only when the queue has room for two results
  assign advance    = in_valid_q && (fifo_cnt <= srp_pkg::FifoCntW'(srp_pkg::FifoDepth - 2));
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_valid_o = fifo_cnt != '0;
  assign pop        = out_valid_o && !out_stall_i;

  always_comb begin
    priority if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      max_entries_q <= srp_pkg::MaxEntriesReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_entries_q <= cfg_max_entries_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_byte_i;
      eof_q  <= end_of_file_i;
    end
  end

  srp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .char_byte_i   (char_q),
    .end_of_file_i (eof_q),
    .max_entries_i (max_entries_q),
    .push_o        (push)
  );

  srp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_cnt)
  );

  assign kind_o        = head.kind;
  assign day_o         = head.day;
  assign start_val_o   = head.start_val;
  assign end_val_o     = head.end_val;
  assign entry_count_o = head.entry_count;
  assign error_code_o  = head.error_code;
  assign line_number_o = head.line_number;
  assign last_o        = head.last;

endmodule

`default_nettype wire

### tb/sv/srp_parse_check.sv
// Checker for the schedule record parser: predicts results per byte and compares them.
module srp_parse_check import srp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [9:0]        cfg_max_entries_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [7:0]        char_byte_i,
  input  logic              end_of_file_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        kind_i,
  input  logic [3:0]        day_i,
  input  logic [13:0]       start_val_i,
  input  logic [13:0]       end_val_i,
  input  logic [9:0]        entry_count_i,
  input  logic [2:0]        error_code_i,
  input  logic [15:0]       line_number_i,
  input  logic              last_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    AT_LINE,
    IN_COMMENT,
    WANT_SP1,
    IN_START,
    WANT_SP2,
    IN_END,
    WANT_NL
  } parse_phase_e;

  parse_phase_e phase;
  logic [1:0]   digit_idx;
  logic [13:0]  acc;
  logic [3:0]   held_day;
  logic [13:0]  held_start;
  logic [9:0]   entries;
  logic [15:0]  line_no;
  logic         cr_skipped;
  logic         draining;
  logic [9:0]   entry_limit;

  srp_result_t  expected_results[$];
  srp_result_t  oldest;
  int unsigned  mismatches = 0;
  int unsigned  waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o = waiting;

  task automatic restart_file();
    phase = AT_LINE;
    digit_idx = '0;
    acc = '0;
    held_day = '0;
    held_start = '0;
    entries = '0;
    line_no = 16'd1;
    cr_skipped = 1'b0;
  endtask

  task automatic next_line();
    if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
  endtask

  task automatic push_result(input kind_e k, input logic [3:0] d, input logic [13:0] st,
                             input logic [13:0] et, input err_e code,
                             input logic [15:0] ln, input logic lst);
    srp_result_t r;
    r.kind = k;
    r.day = d;
    r.start_val = st;
    r.end_val = et;
    r.entry_count = entries;
    r.error_code = code;
    r.line_number = ln;
    r.last = lst;
    expected_results.push_back(r);
  endtask

  // Final result of a file: restart on the end marker, otherwise drop bytes up to it.
  task automatic end_file(input kind_e k, input err_e code, input logic eof);
    push_result(k, 4'd0, 14'd0, 14'd0, code, line_no, 1'b1);
    if (eof) restart_file();
    else draining = 1'b1;
  endtask

  task automatic start_line(input logic [7:0] c, input logic eof);
    phase = AT_LINE;
    if (entries >= entry_limit) end_file(KIND_ERROR, ERR_TOO_MANY, eof);
    else if (eof) end_file(KIND_DONE, ERR_DIGIT, 1'b1);  // code field reads zero on success
    else if (c == ChSemicolon) phase = IN_COMMENT;
    else if (c == ChNl) next_line();
    else if (c >= ChZero && c <= ChNine) begin
      held_day = 4'(c - ChZero);
      phase = WANT_SP1;
    end else end_file(KIND_ERROR, ERR_DIGIT, 1'b0);
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic eof);
    logic        is_dig;
    logic        is_sp;
    logic        is_nl;
    logic [15:0] entry_line;
    if (draining) begin
      if (eof) begin
        draining = 1'b0;
        restart_file();
      end
      return;
    end
    // Drop a lone carriage return; a second one in a row passes through.
    if (!eof && c == ChCr && !cr_skipped) begin
      cr_skipped = 1'b1;
      return;
    end
    cr_skipped = 1'b0;
    is_dig = !eof && c >= ChZero && c <= ChNine;
    is_sp = !eof && c == ChSpace;
    is_nl = !eof && c == ChNl;
    case (phase)
      IN_COMMENT: begin
        if (eof) start_line(c, eof);
        else if (is_nl) begin
          next_line();
          phase = AT_LINE;
        end
      end
      WANT_SP1, WANT_SP2: begin
        if (!is_sp) end_file(KIND_ERROR, ERR_SPACE, eof);
        else begin
          if (phase == WANT_SP1) phase = IN_START;
          else phase = IN_END;
          digit_idx = '0;
          acc = '0;
        end
      end
      IN_START, IN_END: begin
        if (!is_dig) end_file(KIND_ERROR, ERR_FOUR_DIG, eof);
        else begin
          acc = acc * 14'd10 + 14'(c - ChZero);
          digit_idx = digit_idx + 2'd1;
          if (digit_idx == 2'd0) begin
            if (phase == IN_START) begin
              held_start = acc;
              phase = WANT_SP2;
            end else phase = WANT_NL;
          end
        end
      end
      WANT_NL: begin
        entry_line = line_no;
        if (!is_nl) end_file(KIND_ERROR, ERR_NEWLINE, eof);
        else begin
          entries = entries + 10'd1;
          next_line();
          phase = AT_LINE;
          if (entries >= entry_limit) begin
            push_result(KIND_ENTRY, held_day, held_start, acc, ERR_DIGIT, entry_line, 1'b0);
            end_file(KIND_ERROR, ERR_TOO_MANY, 1'b0);
          end else begin
            push_result(KIND_ENTRY, held_day, held_start, acc, ERR_DIGIT, entry_line, 1'b1);
          end
        end
      end
      default: start_line(c, eof);
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_limit = MaxEntriesReset;
      draining = 1'b0;
      restart_file();
      expected_results.delete();
      waiting = 0;
    end else begin
      // Compare results before predicting, so a result can never match its own byte.
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d, line %0d", kind_i, line_number_i);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("kind", oldest.kind, kind_i);
          check_field("day", oldest.day, day_i);
          check_field("start_val", oldest.start_val, start_val_i);
          check_field("end_val", oldest.end_val, end_val_i);
          check_field("entry_count", oldest.entry_count, entry_count_i);
          check_field("error_code", oldest.error_code, error_code_i);
          check_field("line_number", oldest.line_number, line_number_i);
          check_field("last", oldest.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) parse_byte(char_byte_i, end_of_file_i);
      if (cfg_valid_i && cfg_ready_i) entry_limit = cfg_max_entries_i;
      waiting = expected_results.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
// Testbench top for the schedule record parser: byte stimulus, limit writes and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import srp_pkg::*;

  localparam int unsigned QuietLimit = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_max_entries = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_byte = '0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  day;
  logic [13:0] start_val;
  logic [13:0] end_val;
  logic [9:0]  entry_count;
  logic [2:0]  error_code;
  logic [15:0] line_number;
  logic        last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct = 0;
  bit          quiet_run = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned items_sent = 0;
  logic [7:0]  tx_bytes[$];

  int unsigned limit_plan[6] = '{1023, 1, 2, 0, 3, 64};
  int unsigned phase_items[6] = '{160, 140, 150, 60, 150, 160};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  schedule_record_parser dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_max_entries_i (cfg_max_entries),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .char_byte_i       (char_byte),
    .end_of_file_i     (end_of_file),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .kind_o            (kind),
    .day_o             (day),
    .start_val_o       (start_val),
    .end_val_o         (end_val),
    .entry_count_o     (entry_count),
    .error_code_o      (error_code),
    .line_number_o     (line_number),
    .last_o            (last)
  );

  srp_parse_check parse_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_max_entries_i (cfg_max_entries),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .char_byte_i       (char_byte),
    .end_of_file_i     (end_of_file),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .kind_i            (kind),
    .day_i             (day),
    .start_val_i       (start_val),
    .end_val_i         (end_val),
    .entry_count_i     (entry_count),
    .error_code_i      (error_code),
    .line_number_i     (line_number),
    .last_i            (last),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        stall_left = $urandom_range(150, 250);
        long_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!quiet_run && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] c, input logic eof);
    int unsigned gap;
    @(negedge clk);
    if (!quiet_run && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    char_byte <= c;
    end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_eof();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic flush_bytes();
    while (tx_bytes.size() > 0) send_item(tx_bytes.pop_front(), 1'b0);
  endtask

  // Drop valid and wait until every predicted result has drained out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endtask

  function automatic int unsigned pick_time();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 9999;
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  function automatic logic [7:0] comment_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ChNl);
    return b;
  endfunction

  task automatic queue_record(input bit with_cr);
    queue_text($sformatf("%0d %04d %04d", $urandom_range(0, 9), pick_time(), pick_time()));
    if (with_cr) tx_bytes.push_back(ChCr);
    tx_bytes.push_back(ChNl);
  endtask

  task automatic send_file();
    int unsigned lines;
    int unsigned sel;
    int unsigned base;
    int unsigned pos;
    int unsigned keep;
    lines = $urandom_range(0, 6);
    repeat (lines) begin
      sel = $urandom_range(0, 99);
      base = tx_bytes.size();
      if (sel < 62) begin
        queue_record($urandom_range(0, 3) == 0);
      end else if (sel < 74) begin
        tx_bytes.push_back(ChSemicolon);
        repeat ($urandom_range(0, 6)) tx_bytes.push_back(comment_byte());
        tx_bytes.push_back(ChNl);
      end else if (sel < 84) begin
        if ($urandom_range(0, 1) == 1) tx_bytes.push_back(ChCr);
        tx_bytes.push_back(ChNl);
      end else begin
        // Stray carriage return inside a record; a pair of them breaks it.
        queue_record(1'b0);
        pos = base + $urandom_range(0, 11);
        tx_bytes.insert(pos, ChCr);
        if ($urandom_range(0, 4) == 0) tx_bytes.insert(pos, ChCr);
      end
    end
    sel = $urandom_range(0, 99);
    base = tx_bytes.size();
    if (sel < 50) begin
      // clean end of file
    end else if (sel < 62) begin
      tx_bytes.push_back(ChSemicolon);
      repeat ($urandom_range(0, 4)) tx_bytes.push_back(comment_byte());
    end else if (sel < 80) begin
      queue_record(1'b0);
      keep = $urandom_range(1, 11);
      while (tx_bytes.size() > base + keep) void'(tx_bytes.pop_back());
    end else if (sel < 92) begin
      queue_record($urandom_range(0, 1) == 1);
      pos = base + $urandom_range(0, 11);
      tx_bytes[pos] = 8'($urandom_range(0, 255));
      repeat ($urandom_range(0, 3)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
    end
    flush_bytes();
    send_eof();
  endtask

  initial begin : stimulus
    int unsigned target;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extreme record with CRLF, comment, empty line, end marker where a newline belongs.
    idle_pct = 20;
    queue_text("0 0000 9999");
    tx_bytes.push_back(ChCr);
    tx_bytes.push_back(ChNl);
    queue_text(";~\n\n9 9999 0000");
    flush_bytes();
    send_eof();

    for (int p = 0; p < 6; p++) begin
      // Leave the file open after one record so the new limit applies mid-file.
      if (p != 0) begin
        queue_record(1'b0);
        flush_bytes();
      end
      settle();
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_max_entries <= limit_plan[p][9:0];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
      cfg_valid <= 1'b0;

      idle_pct = (p % 3 == 1) ? 0 : ((p % 3 == 0) ? 25 : 45);
      quiet_run = (p == 5);
      if (p == 0) begin
        // Report an entry, then an error on a stray byte at the next line start.
        queue_text("5 1234 5678\n~");
        repeat (3) tx_bytes.push_back(8'($urandom_range(0, 255)));
        flush_bytes();
        send_eof();
      end
      if (p == 2) long_hold_req = 1'b1;
      target = items_sent + phase_items[p];
      while (items_sent < target) begin
        send_file();
        if ($urandom_range(0, 7) == 0) settle();
      end
    end

    settle();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
design/srp_pkg.sv
design/srp_parser.sv
design/srp_out_fifo.sv
design/schedule_record_parser.sv
tb/sv/srp_parse_check.sv
tb/sv/tb_top.sv
